/* src/pfe_pkg.sv */
// Shared types and constants of the postfix expression evaluator.
package pfe_pkg;

  // Result status codes; an error code is sticky until the end of an expression.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_DIVZERO   = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int unsigned RESULT_W = 32;

endpackage

/* src/pfe_if.sv */
// Valid/ready channel interfaces for characters in and results out.
interface pfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface pfe_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_value;
  logic [2:0]  status;

  modport source (output valid, output result_value, output status, input ready);
  modport sink   (input valid, input result_value, input status, output ready);
endinterface

/* src/pfe_stack_mem.sv */
// Operand stack storage below the top entry: one write port, one registered read port.
module pfe_stack_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned W     = 32,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/pfe_alu.sv */
// Iterative shared-adder unit: add, subtract, shift-add multiply, restoring divide.
module pfe_alu #(
  parameter int unsigned W = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pfe_pkg::alu_req_t req_i,
  input  logic [W-1:0]      a_i,
  input  logic [W-1:0]      b_i,
  output logic [W-1:0]      res_o,
  output logic              done_o
);

  localparam int unsigned CW = $clog2(W + 1);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_MUL,
    PH_DIV,
    PH_FIX
  } phase_e;

  phase_e        phase_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  x_q;
  logic [W-1:0]  y_q;
  logic [W-1:0]  acc_q;
  logic [W-1:0]  res_q;
  logic          neg_q;
  logic          done_q;

  logic [W:0]    opa;
  logic [W:0]    opb;
  logic          cin;
  logic [W+1:0]  sum;
  logic [W-1:0]  a_mag;
  logic [W-1:0]  b_mag;

  assign a_mag = a_i[W-1] ? (~a_i + 1'b1) : a_i;
  assign b_mag = b_i[W-1] ? (~b_i + 1'b1) : b_i;

  // One adder serves every operation; operands are selected by phase.
  always_comb begin
    opa = '0;
    opb = '0;
    cin = 1'b0;
    case (phase_q)
      PH_IDLE: begin
        opa = {1'b0, b_i};
        if (req_i.op == pfe_pkg::ALU_SUB) begin
          opb = {1'b0, ~a_i};
          cin = 1'b1;
        end else begin
          opb = {1'b0, a_i};
        end
      end
      PH_MUL: begin
        opa = {1'b0, acc_q};
        opb = x_q[0] ? {1'b0, y_q} : '0;
      end
      PH_DIV: begin
        // trial subtract of divisor from the shifted remainder
        opa = {acc_q, x_q[W-1]};
        opb = ~{1'b0, y_q};
        cin = 1'b1;
      end
      PH_FIX: begin
        if (neg_q) begin
          opb = {1'b0, ~x_q};
          cin = 1'b1;
        end else begin
          opa = {1'b0, x_q};
        end
      end
      default: begin
        opa = '0;
      end
    endcase
    sum = {1'b0, opa} + {1'b0, opb} + {{(W + 1){1'b0}}, cin};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      case (phase_q)
        PH_IDLE: begin
          if (req_i.start) begin
            case (req_i.op)
              pfe_pkg::ALU_ADD, pfe_pkg::ALU_SUB: begin
                res_q  <= sum[W-1:0];
                done_q <= 1'b1;
              end
              pfe_pkg::ALU_MUL: begin
                x_q     <= a_i;
                y_q     <= b_i;
                acc_q   <= '0;
                cnt_q   <= CW'(W);
                done_q  <= 1'b0;
                phase_q <= PH_MUL;
              end
              pfe_pkg::ALU_DIV: begin
                x_q     <= b_mag;
                y_q     <= a_mag;
                acc_q   <= '0;
                neg_q   <= a_i[W-1] ^ b_i[W-1];
                cnt_q   <= CW'(W);
                done_q  <= 1'b0;
                phase_q <= PH_DIV;
              end
              default: begin
                done_q <= 1'b1;
              end
            endcase
          end else begin
            done_q <= 1'b0;
          end
        end
        PH_MUL: begin
          acc_q <= sum[W-1:0];
          x_q   <= x_q >> 1;
          y_q   <= y_q << 1;
          cnt_q <= cnt_q - CW'(1);
          if (cnt_q == CW'(1)) begin
            res_q   <= sum[W-1:0];
            done_q  <= 1'b1;
            phase_q <= PH_IDLE;
          end else begin
            done_q <= 1'b0;
          end
        end
        PH_DIV: begin
          // keep the difference when it did not borrow
          if (sum[W+1]) begin
            acc_q <= sum[W-1:0];
          end else begin
            acc_q <= {acc_q[W-2:0], x_q[W-1]};
          end
          x_q    <= {x_q[W-2:0], sum[W+1]};
          cnt_q  <= cnt_q - CW'(1);
          done_q <= 1'b0;
          if (cnt_q == CW'(1)) begin
            phase_q <= PH_FIX;
          end
        end
        PH_FIX: begin
          res_q   <= sum[W-1:0];
          done_q  <= 1'b1;
          phase_q <= PH_IDLE;
        end
        default: begin
          done_q  <= 1'b0;
          phase_q <= PH_IDLE;
        end
      endcase
    end
  end

  assign res_o  = res_q;
  assign done_o = done_q;

endmodule

/* src/postfix_expression_evaluator.sv */
// Postfix evaluator top level. A digit, '.', or ignored character is handled in the idle state.
// '+' and '-' pass through the load and calc states; '*' and '/' wait in calc on the
// bit-per-cycle multiply and divide of the shared adder unit.
// A last item's result goes to a pending register, then to the output register once it is free.
// Reset (async, active low) clears count, accumulator, error and output valid;
// stack storage is not cleared and is read only where previously written.
module postfix_expression_evaluator #(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  pfe_in_if.sink           in_i,
  pfe_out_if.source        out_o
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned RW = pfe_pkg::RESULT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_CALC,
    S_EMIT
  } state_e;

  state_e             state_q;
  logic [CW-1:0]      count_q;
  logic [W-1:0]       accum_q;
  logic [W-1:0]       tos_q;
  pfe_pkg::status_e   err_q;
  pfe_pkg::alu_op_e   op_q;
  logic [RW-1:0]      pend_val_q;
  pfe_pkg::status_e   pend_st_q;
  logic               out_valid_q;
  logic [RW-1:0]      out_val_q;
  pfe_pkg::status_e   out_st_q;

  logic               in_fire;
  logic               is_digit;
  logic               is_dot;
  logic               is_op;
  pfe_pkg::alu_op_e   dec_op;
  logic [3:0]         digit;
  logic [W-1:0]       accum_next;
  logic [CW-1:0]      count_m1;
  logic [CW-1:0]      count_m2;
  logic               stack_full;
  logic [RW-1:0]      tos_ext;
  pfe_pkg::status_e   end_status;
  logic               mem_we;
  logic               mem_re;
  logic [W-1:0]       mem_rdata;
  pfe_pkg::alu_req_t  alu_req;
  logic [W-1:0]       alu_res;
  logic               alu_done;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    is_dot = 1'b0;
    is_op  = 1'b1;
    dec_op = pfe_pkg::ALU_ADD;
    case (in_i.char_code)
      pfe_pkg::CH_DOT: begin
        is_dot = 1'b1;
        is_op  = 1'b0;
      end
      pfe_pkg::CH_PLUS:  dec_op = pfe_pkg::ALU_ADD;
      pfe_pkg::CH_MINUS: dec_op = pfe_pkg::ALU_SUB;
      pfe_pkg::CH_STAR:  dec_op = pfe_pkg::ALU_MUL;
      pfe_pkg::CH_SLASH: dec_op = pfe_pkg::ALU_DIV;
      default:           is_op  = 1'b0;
    endcase
  end

  assign is_digit   = (in_i.char_code >= pfe_pkg::CH_ZERO) &&
                      (in_i.char_code <= pfe_pkg::CH_NINE);
  assign digit      = 4'(in_i.char_code - pfe_pkg::CH_ZERO);
  assign accum_next = (accum_q << 3) + (accum_q << 1) + W'(digit);
  assign count_m1   = count_q - CW'(1);
  assign count_m2   = count_q - CW'(2);
  assign stack_full = (count_q == CW'(STACK_DEPTH));

  generate
    if (W >= RW) begin : g_trunc
      assign tos_ext = tos_q[RW-1:0];
    end else begin : g_sext
      assign tos_ext = {{(RW - W){tos_q[W-1]}}, tos_q};
    end
  endgenerate

  always_comb begin
    if (err_q != pfe_pkg::ST_OK) begin
      end_status = err_q;
    end else if (count_q == '0) begin
      end_status = pfe_pkg::ST_EMPTY;
    end else begin
      end_status = pfe_pkg::ST_OK;
    end
  end

  // The top entry lives in tos_q; the memory holds the entries below it.
  assign mem_we = in_fire && !in_i.is_last && !is_digit && is_dot &&
                  !stack_full && (count_q != '0);
  assign mem_re = in_fire && !in_i.is_last && is_op && (count_q >= CW'(2));

  pfe_stack_mem #(
    .DEPTH (STACK_DEPTH),
    .W     (W)
  ) u_stack_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_m1[AW-1:0]),
    .wdata_i (tos_q),
    .re_i    (mem_re),
    .raddr_i (count_m2[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  assign alu_req.start = (state_q == S_LOAD);
  assign alu_req.op    = op_q;

  pfe_alu #(
    .W (W)
  ) u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (tos_q),
    .b_i    (mem_rdata),
    .res_o  (alu_res),
    .done_o (alu_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      accum_q     <= '0;
      err_q       <= pfe_pkg::ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            if (in_i.is_last) begin
              pend_val_q <= (count_q == '0) ? '0 : tos_ext;
              pend_st_q  <= end_status;
              count_q    <= '0;
              accum_q    <= '0;
              err_q      <= pfe_pkg::ST_OK;
              state_q    <= S_EMIT;
            end else if (is_digit) begin
              accum_q <= accum_next;
            end else begin
              accum_q <= '0;
              if (is_dot) begin
                if (stack_full) begin
                  if (err_q == pfe_pkg::ST_OK) begin
                    err_q <= pfe_pkg::ST_OVERFLOW;
                  end
                end else begin
                  tos_q   <= accum_q;
                  count_q <= count_q + CW'(1);
                end
              end else if (is_op) begin
                if (count_q < CW'(2)) begin
                  if (err_q == pfe_pkg::ST_OK) begin
                    err_q <= pfe_pkg::ST_UNDERFLOW;
                  end
                end else if ((dec_op == pfe_pkg::ALU_DIV) && (tos_q == '0)) begin
                  if (err_q == pfe_pkg::ST_OK) begin
                    err_q <= pfe_pkg::ST_DIVZERO;
                  end
                end else begin
                  op_q    <= dec_op;
                  state_q <= S_LOAD;
                end
              end
            end
          end
        end
        S_LOAD: begin
          state_q <= S_CALC;
        end
        S_CALC: begin
          if (alu_done) begin
            tos_q   <= alu_res;
            count_q <= count_m1;
            state_q <= S_IDLE;
          end
        end
        S_EMIT: begin
          // hold the result until the output register is free
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_val_q   <= pend_val_q;
            out_st_q    <= pend_st_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_value = out_val_q;
  assign out_o.status       = out_st_q;

endmodule

/* src/pfe_checker.sv */
// Port-level checker for the postfix evaluator, bound to the top level.
module pfe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_is_last_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_result_value_i,
  input logic [2:0]  out_status_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_result_value_i) &&
                                    $stable(out_status_i))
    else $error("result changed or dropped while stalled");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_status_i <= pfe_pkg::ST_EMPTY)
    else $error("status code out of range");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i == pfe_pkg::ST_EMPTY) |-> out_result_value_i == '0)
    else $error("empty stack result is not zero");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i && in_is_last_i, 2))
    else $error("result appeared without a last transfer");

  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_is_last_i |=> !in_ready_i)
    else $error("input ready right after a last transfer");

endmodule

bind postfix_expression_evaluator pfe_checker u_pfe_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_i.valid),
  .in_ready_i         (in_i.ready),
  .in_is_last_i       (in_i.is_last),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .out_result_value_i (out_o.result_value),
  .out_status_i       (out_o.status)
);

/* sim/tb.sv */
// Testbench for the postfix expression evaluator: directed and random expressions.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STACK_SLOTS = 16;

  typedef struct {
    logic [31:0]      value;
    pfe_pkg::status_e status;
  } rpn_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  pfe_in_if  in_ch ();
  pfe_out_if out_ch ();

  postfix_expression_evaluator #(
    .STACK_DEPTH(STACK_SLOTS),
    .VALUE_WIDTH(pfe_pkg::RESULT_W)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always #1 clk_i = ~clk_i;

  // Expected calculator state.
  logic [31:0]      calc_stack [STACK_SLOTS];
  int               calc_depth = 0;
  logic [31:0]      calc_accum = '0;
  pfe_pkg::status_e calc_err   = pfe_pkg::ST_OK;

  rpn_result_t expected_results [$];
  int          fail_count   = 0;
  int          sig_items    = 0;
  bit          idle_on      = 1'b1;
  bit          gaps_on      = 1'b0;

  function automatic bit is_digit(input logic [7:0] c);
    return c >= pfe_pkg::CH_ZERO && c <= pfe_pkg::CH_NINE;
  endfunction

  function automatic bit is_operator(input logic [7:0] c);
    return c == pfe_pkg::CH_PLUS || c == pfe_pkg::CH_MINUS ||
           c == pfe_pkg::CH_STAR || c == pfe_pkg::CH_SLASH;
  endfunction

  function automatic void note_error(input pfe_pkg::status_e code);
    if (calc_err == pfe_pkg::ST_OK) calc_err = code;
  endfunction

  function automatic void evaluate_char(input logic [7:0] c, input logic last);
    rpn_result_t res;
    logic [31:0] a, b, r, mag_a, mag_b, quo;
    bit          do_pop;
    if (last) begin
      res.value = (calc_depth > 0) ? calc_stack[calc_depth-1] : '0;
      if (calc_err != pfe_pkg::ST_OK) res.status = calc_err;
      else if (calc_depth == 0) res.status = pfe_pkg::ST_EMPTY;
      else res.status = pfe_pkg::ST_OK;
      expected_results.push_back(res);
      calc_depth = 0;
      calc_accum = '0;
      calc_err   = pfe_pkg::ST_OK;
      return;
    end
    if (is_digit(c)) begin
      calc_accum = calc_accum * 32'd10 + 32'(c - pfe_pkg::CH_ZERO);
      return;
    end
    if (c == pfe_pkg::CH_DOT) begin
      if (calc_depth >= STACK_SLOTS) begin
        note_error(pfe_pkg::ST_OVERFLOW);
      end else begin
        calc_stack[calc_depth] = calc_accum;
        calc_depth++;
      end
    end else if (is_operator(c)) begin
      if (calc_depth < 2) begin
        note_error(pfe_pkg::ST_UNDERFLOW);
      end else begin
        a      = calc_stack[calc_depth-1];
        b      = calc_stack[calc_depth-2];
        r      = '0;
        do_pop = 1'b1;
        case (c)
          pfe_pkg::CH_PLUS:  r = b + a;
          pfe_pkg::CH_MINUS: r = b - a;
          pfe_pkg::CH_STAR:  r = a * b;
          default: begin
            if (a == '0) begin
              note_error(pfe_pkg::ST_DIVZERO);
              do_pop = 1'b0;
            end else begin
              // divide magnitudes, then fix the sign; truncates toward zero
              mag_a = a[31] ? -a : a;
              mag_b = b[31] ? -b : b;
              quo   = mag_b / mag_a;
              r     = (a[31] ^ b[31]) ? -quo : quo;
            end
          end
        endcase
        if (do_pop) begin
          calc_depth--;
          calc_stack[calc_depth-1] = r;
        end
      end
    end
    calc_accum = '0;
  endfunction

  task automatic send_char(input logic [7:0] c, input logic last);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.char_code <= c;
    in_ch.is_last   <= last;
    do @(posedge clk_i); while (!in_ch.ready);
    evaluate_char(c, last);
    if (last || is_digit(c) || c == pfe_pkg::CH_DOT || is_operator(c)) sig_items++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
  endtask

  function automatic logic [7:0] random_operator();
    case ($urandom_range(0, 3))
      0:       return pfe_pkg::CH_PLUS;
      1:       return pfe_pkg::CH_MINUS;
      2:       return pfe_pkg::CH_STAR;
      default: return pfe_pkg::CH_SLASH;
    endcase
  endfunction

  function automatic logic [7:0] random_ignored_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (is_digit(c) || c == pfe_pkg::CH_DOT || is_operator(c));
    return c;
  endfunction

  task automatic send_number();
    int n, k;
    case ($urandom_range(0, 19))
      0:       n = 0;
      1:       n = $urandom_range(11, 13);  // can wrap the accumulator
      2, 3, 4: n = $urandom_range(7, 10);
      default: n = $urandom_range(1, 4);
    endcase
    for (k = 0; k < n; k++) send_char(pfe_pkg::CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
    send_char(pfe_pkg::CH_DOT, 1'b0);
  endtask

  // Mostly well-formed expressions with random content; broken ones get raw
  // characters up front and may leave extra values behind.
  task automatic send_expression(input bit broken);
    int  depth, pushes, target, k;
    bit  deep;
    gaps_on = idle_on && $urandom_range(0, 2) != 0;
    deep    = $urandom_range(0, 11) == 0;
    target  = deep ? $urandom_range(15, 19) : $urandom_range(1, 6);
    depth   = 0;
    pushes  = 0;
    if (broken) begin
      for (k = $urandom_range(1, 4); k > 0; k--) begin
        if ($urandom_range(0, 1)) send_char(random_operator(), 1'b0);
        else send_char(8'($urandom_range(0, 255)), 1'b0);
      end
    end
    while (pushes < target || depth > 1) begin
      if (pushes < target && (deep || depth < 2 || $urandom_range(0, 1))) begin
        send_number();
        depth++;
        pushes++;
      end else begin
        send_char(random_operator(), 1'b0);
        depth--;
      end
      if ($urandom_range(0, 9) == 0) send_char(random_ignored_char(), 1'b0);
    end
    if (broken && $urandom_range(0, 1)) send_number();
    send_char(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic test_directed();
    gaps_on = 1'b1;
    // most negative value, then divided by -1
    send_text("65536.32768.*.1.-/");
    send_char(8'h00, 1'b1);
    // one value, then an operator
    send_text("4.+");
    send_char(pfe_pkg::CH_PLUS, 1'b1);
    // divide by zero, with ignored characters at the code extremes
    send_text("9.0.");
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b0);
    send_text("/");
    send_char(pfe_pkg::CH_SLASH, 1'b1);
    // nothing pushed
    send_char(8'hFF, 1'b1);
  endtask

  task automatic test_random_expressions(input int item_goal);
    while (sig_items < item_goal) send_expression($urandom_range(0, 4) == 0);
  endtask

  task automatic test_back_to_back(input int item_goal);
    idle_on = 1'b0;
    while (sig_items < item_goal) send_expression($urandom_range(0, 4) == 0);
  endtask

  // Receiver: random stall bursts, enabled in windows so quiet stretches occur.
  initial begin
    int stall_left, window;
    bit stall_on;
    out_ch.ready = 1'b0;
    stall_left   = 0;
    window       = 0;
    stall_on     = 1'b0;
    forever begin
      @(negedge clk_i);
      if (window == 0) begin
        window   = 64;
        stall_on = $urandom_range(0, 2) != 0;
      end
      window--;
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (idle_on && stall_on && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 8);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk_i) begin
    rpn_result_t exp_res;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected result: value %0d status %0d",
                   $signed(out_ch.result_value), out_ch.status);
        fail_count++;
      end else begin
        exp_res = expected_results.pop_front();
        if (out_ch.result_value !== exp_res.value || out_ch.status !== exp_res.status) begin
          if (fail_count < 10)
            $display("mismatch: expected value %0d status %0d, got value %0d status %0d",
                     $signed(exp_res.value), exp_res.status,
                     $signed(out_ch.result_value), out_ch.status);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.char_code = '0;
    in_ch.is_last   = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random_expressions(850);
    test_back_to_back(1050);
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    // drain: longest operation is a divide
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* files.f */
src/pfe_pkg.sv
src/pfe_if.sv
src/pfe_stack_mem.sv
src/pfe_alu.sv
src/postfix_expression_evaluator.sv
src/pfe_checker.sv
sim/tb.sv
